// File: rtl/core/bbr_pkg.sv
// ----------------------------------------------------------------------------
// bbr_pkg
// Shared types, codes, reset values and glyph lookup for the ball raster.
// ----------------------------------------------------------------------------
package bbr_pkg;

    localparam int BBR_SCREEN_WIDTH  = 78;
    localparam int BBR_SCREEN_HEIGHT = 64;
    localparam int BBR_FRAC_BITS     = 8;

    localparam logic [4:0]         BBR_RADIUS_RST      = 5'd12;
    localparam logic [9:0]         BBR_GRAVITY_RST     = 10'd48;
    localparam logic signed [11:0] BBR_START_SPEED_RST = 12'sd256;

    localparam logic [6:0] GLYPH_SPACE = 7'd32;
    localparam logic [6:0] GLYPH_UNDER = 7'd95;
    localparam logic [6:0] GLYPH_CARET = 7'd94;
    localparam logic [6:0] GLYPH_FULL  = 7'd67;

    typedef enum logic [1:0] {
        FUNC_TICK    = 2'd0,
        FUNC_QUERY   = 2'd1,
        FUNC_RESTART = 2'd2
    } t_func;

    typedef enum logic [1:0] {
        CFG_RADIUS      = 2'd0,
        CFG_GRAVITY     = 2'd1,
        CFG_START_SPEED = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [4:0]         radius;
        logic [9:0]         gravity_step;
        logic signed [11:0] start_speed_x;
    } t_cfg;

    function automatic logic [6:0] bbr_glyph(input logic [1:0] pair);
        logic [6:0] g;
        case (pair)
            2'd0:    g = GLYPH_SPACE;
            2'd1:    g = GLYPH_UNDER;
            2'd2:    g = GLYPH_CARET;
            default: g = GLYPH_FULL;
        endcase
        return g;
    endfunction

endpackage

// File: rtl/core/bbr_cfg_regs.sv
// ----------------------------------------------------------------------------
// bbr_cfg_regs
// Configuration register file: radius, gravity step and restart speed.
// ----------------------------------------------------------------------------
module bbr_cfg_regs (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_valid,
    input  logic [1:0]    i_cfg_index,
    input  logic [11:0]   i_cfg_data,
    output bbr_pkg::t_cfg o_cfg
);
    import bbr_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.radius        <= BBR_RADIUS_RST;
            r_cfg.gravity_step  <= BBR_GRAVITY_RST;
            r_cfg.start_speed_x <= BBR_START_SPEED_RST;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_RADIUS:      r_cfg.radius        <= i_cfg_data[4:0];
                CFG_GRAVITY:     r_cfg.gravity_step  <= i_cfg_data[9:0];
                CFG_START_SPEED: r_cfg.start_speed_x <= $signed(i_cfg_data);
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: rtl/core/bbr_motion.sv
// ----------------------------------------------------------------------------
// bbr_motion
// Ball state: gravity, position update, wall clamp and reflection, restart.
// ----------------------------------------------------------------------------
module bbr_motion #(
    parameter int SCREEN_WIDTH  = bbr_pkg::BBR_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = bbr_pkg::BBR_SCREEN_HEIGHT,
    parameter int FRAC_BITS     = bbr_pkg::BBR_FRAC_BITS
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  bbr_pkg::t_cfg  i_cfg,
    input  logic           i_step,
    input  bbr_pkg::t_func i_func,
    output logic [14:0]    o_pos_x,
    output logic [14:0]    o_pos_y,
    output logic [14:0]    o_next_x,
    output logic [14:0]    o_next_y
);
    import bbr_pkg::*;

    localparam int WIDE = (FRAC_BITS + 11 > 20) ? FRAC_BITS + 11 : 20;
    localparam logic signed [WIDE-1:0] VMAX = WIDE'(32767);
    localparam logic signed [WIDE-1:0] VMIN = WIDE'(-32768);
    localparam logic signed [WIDE-1:0] PMAX = WIDE'(32767);
    localparam logic signed [WIDE-1:0] H_FX = WIDE'(SCREEN_HEIGHT << FRAC_BITS);
    localparam logic signed [WIDE-1:0] W_FX = WIDE'(SCREEN_WIDTH << FRAC_BITS);
    localparam int POS_RST_I = int'(BBR_RADIUS_RST) << FRAC_BITS;
    localparam logic [14:0] POS_RST = (POS_RST_I > 32767) ? 15'h7fff : 15'(POS_RST_I);

    function automatic logic signed [15:0] sat16(input logic signed [WIDE-1:0] v);
        logic signed [15:0] s;
        if (v > VMAX)      s = 16'sh7fff;
        else if (v < VMIN) s = 16'sh8000;
        else               s = v[15:0];
        return s;
    endfunction

    function automatic logic [14:0] sat_pos(input logic signed [WIDE-1:0] v);
        logic [14:0] s;
        if (v > PMAX)              s = 15'h7fff;
        else if (v < WIDE'(0))     s = 15'h0;
        else                       s = v[14:0];
        return s;
    endfunction

    logic [14:0]            r_pos_x, r_pos_y;
    logic signed [15:0]     r_vel_x, r_vel_y;
    logic [14:0]            n_pos_x, n_pos_y;
    logic signed [15:0]     n_vel_x, n_vel_y;
    logic signed [WIDE-1:0] r_fx, g_fx, px, py;
    logic signed [15:0]     vy1;

    assign r_fx = $signed(WIDE'(i_cfg.radius) << FRAC_BITS);
    assign g_fx = $signed(WIDE'(i_cfg.gravity_step));

    always_comb begin
        n_pos_x = r_pos_x;
        n_pos_y = r_pos_y;
        n_vel_x = r_vel_x;
        n_vel_y = r_vel_y;
        vy1     = sat16(WIDE'(r_vel_y) + g_fx);
        px      = $signed(WIDE'(r_pos_x)) + WIDE'(r_vel_x);
        py      = $signed(WIDE'(r_pos_y)) + WIDE'(vy1);
        case (i_func)
            FUNC_TICK: begin
                n_vel_y = vy1;
                if (py + r_fx > H_FX) begin
                    py      = H_FX - r_fx;
                    n_vel_y = sat16(-WIDE'(vy1));
                end else if (py - r_fx <= WIDE'(0)) begin
                    py      = r_fx;
                    n_vel_y = sat16(-WIDE'(vy1));
                end
                if (px + r_fx > W_FX) begin
                    px      = W_FX - r_fx;
                    n_vel_x = sat16(-WIDE'(r_vel_x));
                end else if (px - r_fx < WIDE'(0)) begin
                    px      = r_fx;
                    n_vel_x = sat16(-WIDE'(r_vel_x));
                end
                n_pos_x = sat_pos(px);
                n_pos_y = sat_pos(py);
            end
            FUNC_RESTART: begin
                n_pos_x = sat_pos(r_fx);
                n_pos_y = sat_pos(r_fx);
                n_vel_x = 16'(i_cfg.start_speed_x);
                n_vel_y = '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x <= POS_RST;
            r_pos_y <= POS_RST;
            r_vel_x <= 16'(BBR_START_SPEED_RST);
            r_vel_y <= '0;
        end else if (i_step) begin
            r_pos_x <= n_pos_x;
            r_pos_y <= n_pos_y;
            r_vel_x <= n_vel_x;
            r_vel_y <= n_vel_y;
        end
    end

    assign o_pos_x  = r_pos_x;
    assign o_pos_y  = r_pos_y;
    assign o_next_x = n_pos_x;
    assign o_next_y = n_pos_y;

    a_restart_stops_fall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && i_func == FUNC_RESTART) |=> (r_vel_y == 16'sd0))
        else $error("vertical speed not cleared by restart");

    a_query_keeps_ball: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && i_func == FUNC_QUERY) |=> ($stable(r_pos_x) && $stable(r_pos_y)
            && $stable(r_vel_x) && $stable(r_vel_y)))
        else $error("cell query moved the ball");

endmodule

// File: rtl/core/bbr_cell_geom.sv
// ----------------------------------------------------------------------------
// bbr_cell_geom
// Query geometry: offsets of the two cell pixels from the centre, squared.
// ----------------------------------------------------------------------------
module bbr_cell_geom #(
    parameter int SCREEN_WIDTH  = bbr_pkg::BBR_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = bbr_pkg::BBR_SCREEN_HEIGHT,
    parameter int FRAC_BITS     = bbr_pkg::BBR_FRAC_BITS,
    parameter int MW            = FRAC_BITS + 5
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_v1,
    input  bbr_pkg::t_func i_func,
    input  logic [6:0]     i_col,
    input  logic [4:0]     i_row,
    input  logic [4:0]     i_radius,
    input  logic [14:0]    i_pos_x,
    input  logic [14:0]    i_pos_y,
    input  logic [14:0]    i_next_x,
    input  logic [14:0]    i_next_y,
    input  logic           i_rdy3,
    output logic           o_rdy2,
    output logic           o_v2,
    output logic           o_query,
    output logic           o_top_ok,
    output logic           o_bot_ok,
    output logic [2*MW-1:0] o_sq_x,
    output logic [2*MW-1:0] o_sq_top,
    output logic [2*MW-1:0] o_sq_bot,
    output logic [9:0]     o_rr,
    output logic [14:0]    o_ball_x,
    output logic [14:0]    o_ball_y
);
    import bbr_pkg::*;

    localparam int WIDE = (FRAC_BITS + 11 > 20) ? FRAC_BITS + 11 : 20;
    localparam logic signed [WIDE-1:0] ONE_FX = WIDE'(1 << FRAC_BITS);

    logic signed [WIDE-1:0] r_fx, ix, jt, jb, dx, dyt, dyb, ax, at, ab;
    logic                   okx, okt, okb;
    logic [MW-1:0]          mx, mt, mb;
    logic [5:0]             jrow;

    logic                   r_v2, r_query, r_top_ok, r_bot_ok;
    logic [2*MW-1:0]        r_sq_x, r_sq_top, r_sq_bot;
    logic [9:0]             r_rr;
    logic [14:0]            r_ball_x, r_ball_y;
    logic                   rdy2;

    assign jrow = {i_row, 1'b0};
    assign r_fx = $signed(WIDE'(i_radius) << FRAC_BITS);
    assign ix   = $signed(WIDE'(i_col) << FRAC_BITS);
    assign jt   = $signed(WIDE'(jrow) << FRAC_BITS);
    assign jb   = jt + ONE_FX;
    assign dx   = ix - $signed(WIDE'(i_pos_x));
    assign dyt  = jt - $signed(WIDE'(i_pos_y));
    assign dyb  = jb - $signed(WIDE'(i_pos_y));

    assign okx = (8'(i_col) < 8'(SCREEN_WIDTH)) && (dx < r_fx) && (dx >= -r_fx);
    assign okt = (8'(jrow) < 8'(SCREEN_HEIGHT)) && (dyt < r_fx) && (dyt >= -r_fx);
    assign okb = (8'(jrow) + 8'd1 < 8'(SCREEN_HEIGHT)) && (dyb < r_fx) && (dyb >= -r_fx);

    assign ax = (dx  < WIDE'(0)) ? -dx  : dx;
    assign at = (dyt < WIDE'(0)) ? -dyt : dyt;
    assign ab = (dyb < WIDE'(0)) ? -dyb : dyb;
    assign mx = okx ? ax[MW-1:0] : '0;
    assign mt = okt ? at[MW-1:0] : '0;
    assign mb = okb ? ab[MW-1:0] : '0;

    assign rdy2 = !r_v2 || i_rdy3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (rdy2) begin
            r_v2 <= i_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy2 && i_v1) begin
            r_query  <= (i_func == FUNC_QUERY);
            r_top_ok <= okx && okt;
            r_bot_ok <= okx && okb;
            r_sq_x   <= (2*MW)'(mx) * (2*MW)'(mx);
            r_sq_top <= (2*MW)'(mt) * (2*MW)'(mt);
            r_sq_bot <= (2*MW)'(mb) * (2*MW)'(mb);
            r_rr     <= 10'(i_radius) * 10'(i_radius);
            r_ball_x <= i_next_x;
            r_ball_y <= i_next_y;
        end
    end

    assign o_rdy2   = rdy2;
    assign o_v2     = r_v2;
    assign o_query  = r_query;
    assign o_top_ok = r_top_ok;
    assign o_bot_ok = r_bot_ok;
    assign o_sq_x   = r_sq_x;
    assign o_sq_top = r_sq_top;
    assign o_sq_bot = r_sq_bot;
    assign o_rr     = r_rr;
    assign o_ball_x = r_ball_x;
    assign o_ball_y = r_ball_y;

    a_stage_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && !i_rdy3) |=> (r_v2 && $stable(r_sq_x) && $stable(r_ball_y)))
        else $error("stalled query stage lost its word");

endmodule

// File: rtl/core/bbr_pixel_out.sv
// ----------------------------------------------------------------------------
// bbr_pixel_out
// Distance test for both cell pixels, glyph lookup and output register.
// ----------------------------------------------------------------------------
module bbr_pixel_out #(
    parameter int FRAC_BITS = bbr_pkg::BBR_FRAC_BITS,
    parameter int MW        = FRAC_BITS + 5
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_v2,
    input  logic            i_query,
    input  logic            i_top_ok,
    input  logic            i_bot_ok,
    input  logic [2*MW-1:0] i_sq_x,
    input  logic [2*MW-1:0] i_sq_top,
    input  logic [2*MW-1:0] i_sq_bot,
    input  logic [9:0]      i_rr,
    input  logic [14:0]     i_ball_x,
    input  logic [14:0]     i_ball_y,
    input  logic            i_m_tready,
    output logic            o_rdy3,
    output logic            o_m_tvalid,
    output logic [39:0]     o_m_tdata
);
    import bbr_pkg::*;

    localparam int SW = 2 * MW + 1;

    logic [SW-1:0] sum_t, sum_b, rr_fx;
    logic          lit_t, lit_b, rdy3;
    logic [1:0]    pair;

    logic          r_v3;
    logic [1:0]    r_pair;
    logic [6:0]    r_glyph;
    logic [14:0]   r_ball_x, r_ball_y;

    assign sum_t = SW'(i_sq_x) + SW'(i_sq_top);
    assign sum_b = SW'(i_sq_x) + SW'(i_sq_bot);
    assign rr_fx = SW'(i_rr) << (2 * FRAC_BITS);
    assign lit_t = i_top_ok && (sum_t <= rr_fx);
    assign lit_b = i_bot_ok && (sum_b <= rr_fx);
    assign pair  = i_query ? {lit_t, lit_b} : 2'b00;

    assign rdy3 = !r_v3 || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (rdy3) begin
            r_v3 <= i_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy3 && i_v2) begin
            r_pair   <= pair;
            r_glyph  <= bbr_glyph(pair);
            r_ball_x <= i_ball_x;
            r_ball_y <= i_ball_y;
        end
    end

    assign o_rdy3     = rdy3;
    assign o_m_tvalid = r_v3;
    assign o_m_tdata  = {1'b0, r_ball_y, r_ball_x, r_glyph, r_pair};

    a_word_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_v2 && rdy3) |=> r_v3)
        else $error("result word dropped at output register");

endmodule

// File: rtl/core/bouncing_ball_raster.sv
// ----------------------------------------------------------------------------
// bouncing_ball_raster
// Bouncing ball with gravity for a half-block character display.
//
//   port group | dir | fields (low bit up)
//   i_s_*      | in  | tdata: col[6:0] row[11:7]; tuser: func[1:0]
//   o_m_*      | out | tdata: pixel_pair[1:0] glyph[8:2] ball_x[23:9] ball_y[38:24]
//   i_cfg_*    | in  | index[1:0] data[11:0]; 0 radius, 1 gravity, 2 start speed
//
// One word per cycle while not stalled; input, query and result registers in order.
// Ball state moves as a word leaves the input register, so queries see all
// earlier ticks and restarts. Query stage squares dx, both dy and radius.
// Synchronous reset, no clearing pass; configuration always ready.
// Each stage holds its word while the next is full and stalled.
// ----------------------------------------------------------------------------
module bouncing_ball_raster #(
    parameter int SCREEN_WIDTH  = bbr_pkg::BBR_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = bbr_pkg::BBR_SCREEN_HEIGHT,
    parameter int FRAC_BITS     = bbr_pkg::BBR_FRAC_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // col[6:0], row[11:7], zero fill
    input  logic [1:0]  i_s_tuser,   // func[1:0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata,   // pixel_pair[1:0], glyph[8:2], ball_x[23:9],
                                     // ball_y[38:24], zero fill
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [11:0] i_cfg_data
);
    import bbr_pkg::*;

    localparam int MW = FRAC_BITS + 5;

    t_cfg            cfg;
    logic            r_v1;
    t_func           r_func;
    logic [6:0]      r_col;
    logic [4:0]      r_row;
    logic            rdy1, rdy2, rdy3, adv1;
    logic [14:0]     pos_x, pos_y, next_x, next_y;
    logic            v2, query, top_ok, bot_ok;
    logic [2*MW-1:0] sq_x, sq_top, sq_bot;
    logic [9:0]      rr;
    logic [14:0]     ball_x, ball_y;

    assign o_cfg_ready = 1'b1;
    assign rdy1        = !r_v1 || rdy2;
    assign adv1        = r_v1 && rdy2;
    assign o_s_tready  = rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (rdy1) begin
            r_v1 <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1 && i_s_tvalid) begin
            r_func <= t_func'(i_s_tuser);
            r_col  <= i_s_tdata[6:0];
            r_row  <= i_s_tdata[11:7];
        end
    end

    bbr_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    bbr_motion #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT),
        .FRAC_BITS     (FRAC_BITS)
    ) u_motion (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_step   (adv1),
        .i_func   (r_func),
        .o_pos_x  (pos_x),
        .o_pos_y  (pos_y),
        .o_next_x (next_x),
        .o_next_y (next_y)
    );

    bbr_cell_geom #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT),
        .FRAC_BITS     (FRAC_BITS),
        .MW            (MW)
    ) u_geom (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_v1     (r_v1),
        .i_func   (r_func),
        .i_col    (r_col),
        .i_row    (r_row),
        .i_radius (cfg.radius),
        .i_pos_x  (pos_x),
        .i_pos_y  (pos_y),
        .i_next_x (next_x),
        .i_next_y (next_y),
        .i_rdy3   (rdy3),
        .o_rdy2   (rdy2),
        .o_v2     (v2),
        .o_query  (query),
        .o_top_ok (top_ok),
        .o_bot_ok (bot_ok),
        .o_sq_x   (sq_x),
        .o_sq_top (sq_top),
        .o_sq_bot (sq_bot),
        .o_rr     (rr),
        .o_ball_x (ball_x),
        .o_ball_y (ball_y)
    );

    bbr_pixel_out #(
        .FRAC_BITS (FRAC_BITS),
        .MW        (MW)
    ) u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_v2       (v2),
        .i_query    (query),
        .i_top_ok   (top_ok),
        .i_bot_ok   (bot_ok),
        .i_sq_x     (sq_x),
        .i_sq_top   (sq_top),
        .i_sq_bot   (sq_bot),
        .i_rr       (rr),
        .i_ball_x   (ball_x),
        .i_ball_y   (ball_y),
        .i_m_tready (i_m_tready),
        .o_rdy3     (rdy3),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata)
    );

endmodule
